@@ rtl/orbe_pkg.sv @@
// Shared types and constants for the one-bit RC audio encoder.
package orbe_pkg;

	localparam int SAMPLE_W = 8;
	localparam int LEVEL_W  = 9;
	localparam int SOFT_W   = 8;
	localparam int COUNT_W  = 4;
	localparam int POS_W    = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [LEVEL_W-1:0] LEVEL_RESET = 9'd128;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 9'd256;
	localparam logic [LEVEL_W-1:0] TARGET_BIAS = 9'd64;
	localparam logic [SOFT_W-1:0]  SOFT_RESET  = 8'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_SOFTNESS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MSB_FIRST = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_HI,
		ST_DIV_LO,
		ST_DECIDE
	} state_t;

	// One encoded bit handed to the packer.
	typedef struct packed {
		logic push;
		logic enc_bit;
		logic last;
		logic msb_first;
	} pack_req_t;

endpackage

@@ rtl/orbe_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by both level steps.
module orbe_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [orbe_pkg::LEVEL_W-1:0]  num,
	input  logic [orbe_pkg::SOFT_W-1:0]   den,
	output logic                          done,
	output logic [orbe_pkg::LEVEL_W-1:0]  quot
);
	import orbe_pkg::*;

	logic [SOFT_W-1:0]  rem_q;
	logic [LEVEL_W-1:0] quo_q;
	logic [SOFT_W-1:0]  den_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [SOFT_W:0]    trial;
	logic [SOFT_W+1:0]  diff;
	logic               fits;

	assign trial = {rem_q, quo_q[LEVEL_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign fits  = ~diff[SOFT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == COUNT_W'(LEVEL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			// shift the numerator out, the quotient bit in
			rem_q <= fits ? diff[SOFT_W-1:0] : trial[SOFT_W-1:0];
			quo_q <= {quo_q[LEVEL_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

@@ rtl/orbe_pack.sv @@
// Bit packer and output register for the encoded byte stream.
module orbe_pack (
	input  logic                         clk,
	input  logic                         arst_n,
	input  orbe_pkg::pack_req_t          req,
	output logic                         ready,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   packed_byte,
	output logic [3:0]                   bits_valid,
	output logic                         stream_end
);
	import orbe_pkg::*;

	logic [7:0]       partial_q;
	logic [POS_W-1:0] pos_q;
	logic             out_valid_q;
	logic [7:0]       byte_q;
	logic [3:0]       count_q;
	logic             end_q;

	logic [POS_W-1:0] slot;
	logic [7:0]       merged;
	logic             emit;
	logic             take;

	assign ready  = ~out_valid_q | out_ready;
	assign take   = req.push & ready;
	assign slot   = req.msb_first ? (3'd7 - pos_q) : pos_q;
	assign merged = partial_q | (8'(req.enc_bit) << slot);
	assign emit   = (pos_q == 3'd7) | req.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q   <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (emit) begin
					partial_q   <= '0;
					pos_q       <= '0;
					out_valid_q <= 1'b1;
				end else begin
					partial_q <= merged;
					pos_q     <= pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			byte_q  <= merged;
			count_q <= {1'b0, pos_q} + 4'd1;
			end_q   <= req.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign packed_byte = byte_q;
	assign bits_valid  = count_q;
	assign stream_end  = end_q;

endmodule

@@ rtl/one_bit_rc_audio_encoder.sv @@
// Top level: sequencer and filter level of the one-bit RC audio encoder.
//
//  port group   direction  handshake            payload
//  cfg          in         cfg_we               cfg_index, cfg_data
//  in           in         in_valid/in_ready    sample, sample_last
//  out          out        out_valid/out_ready  packed_byte, bits_valid, stream_end
//
// Each sample is accepted, then makes two passes through the shared divider (charge step,
// then discharge step), and then its bit is decided.
// The decide cycle waits while the output register holds a byte not yet taken.
// Reset restores softness 4, LSB-first packing and a filter level of 128.
// in_ready is high only in the idle state.
module one_bit_rc_audio_encoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [orbe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [orbe_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        sample,
	input  logic                              sample_last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        packed_byte,
	output logic [3:0]                        bits_valid,
	output logic                              stream_end
);
	import orbe_pkg::*;

	state_t             state_q, state_d;
	logic [SOFT_W-1:0]  softness_q;
	logic               msb_first_q;
	logic [LEVEL_W-1:0] level_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic               last_q;
	logic [LEVEL_W-1:0] hi_q;
	logic [LEVEL_W-1:0] lo_q;

	logic               div_start;
	logic [LEVEL_W-1:0] div_num;
	logic [SOFT_W-1:0]  div_den;
	logic               div_done;
	logic [LEVEL_W-1:0] div_quot;

	logic               accept;
	logic               pack_ready;
	pack_req_t          req;

	logic [LEVEL_W-1:0] target;
	logic [LEVEL_W-1:0] dist_hi;
	logic [LEVEL_W-1:0] dist_lo;
	logic               enc_bit;

	assign accept  = in_valid & in_ready;
	assign div_den = (softness_q == '0) ? SOFT_W'(1) : softness_q;

	assign target  = LEVEL_W'(sample_q[SAMPLE_W-1:1]) + TARGET_BIAS;
	assign dist_hi = (hi_q > target) ? (hi_q - target) : (target - hi_q);
	assign dist_lo = (lo_q > target) ? (lo_q - target) : (target - lo_q);
	// a tie goes high
	assign enc_bit = dist_hi <= dist_lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			softness_q  <= SOFT_RESET;
			msb_first_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SOFTNESS:  softness_q  <= cfg_data[SOFT_W-1:0];
				CFG_MSB_FIRST: msb_first_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_DIV_HI;
			ST_DIV_HI: if (div_done) state_d = ST_DIV_LO;
			ST_DIV_LO: if (div_done) state_d = ST_DECIDE;
			ST_DECIDE: if (pack_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		div_start     = 1'b0;
		div_num       = LEVEL_FULL - level_q;
		req.push      = 1'b0;
		req.enc_bit   = enc_bit;
		req.last      = last_q;
		req.msb_first = msb_first_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				div_start = in_valid;
			end
			ST_DIV_HI: begin
				// launch the discharge step as soon as the charge step lands
				div_start = div_done;
				div_num   = level_q;
			end
			ST_DIV_LO: ;
			ST_DECIDE: req.push = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			level_q <= LEVEL_RESET;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DECIDE && pack_ready) begin
				if (last_q) begin
					level_q <= LEVEL_RESET;
				end else begin
					level_q <= enc_bit ? hi_q : lo_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
			last_q   <= sample_last;
		end
		if (state_q == ST_DIV_HI && div_done) begin
			hi_q <= level_q + div_quot;
		end
		if (state_q == ST_DIV_LO && div_done) begin
			lo_q <= level_q - div_quot;
		end
	end

	orbe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	orbe_pack u_pack (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.ready       (pack_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.packed_byte (packed_byte),
		.bits_valid  (bits_valid),
		.stream_end  (stream_end)
	);

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the one-bit RC audio encoder: directed and random samples.
`timescale 1ns / 100ps

module tb_top;
	import orbe_pkg::*;

	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int LATENCY_CYCLES  = 48;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 45;

	// Directed samples: full byte ending a stream, short streams, a tail left
	// open across an order change, zero and maximum softness.
	localparam logic [7:0] DIRECTED_SAMPLES [0:24] = '{
		8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd127, 8'd1, 8'd254,
		8'd255, 8'd0,
		8'd255,
		8'd200, 8'd60, 8'd190,
		8'd255, 8'd0, 8'd128, 8'd129, 8'd0,
		8'd0, 8'd255, 8'd100,
		8'd255, 8'd255, 8'd0
	};
	localparam logic [24:0] DIRECTED_LAST = 25'b1001001_0000000_1101_0000000;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
	typedef enum int {WAVE_UNIFORM, WAVE_WALK, WAVE_RAILS, WAVE_FLAT} wave_t;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} sample_item_t;

	typedef struct packed {
		logic [7:0] code;
		logic [3:0] count;
		logic       end_flag;
	} packed_result_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [7:0]            sample      = '0;
	logic                  sample_last = 1'b0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [7:0]            packed_byte;
	logic [3:0]            bits_valid;
	logic                  stream_end;

	// Predictor state and register copies
	logic [SOFT_W-1:0]  cfg_softness  = SOFT_RESET;
	logic               cfg_msb_first = 1'b0;
	logic [LEVEL_W-1:0] level         = LEVEL_RESET;
	logic [7:0]         byte_acc      = '0;
	logic [3:0]         bits_packed   = '0;

	sample_item_t   sample_queue[$];
	packed_result_t expected_bytes[$];

	int sender_idle_pct   = 0;
	int receiver_stall_pct = 0;
	int items_queued      = 0;
	int samples_taken     = 0;
	int bytes_checked     = 0;
	int streams_closed    = 0;
	int settings_applied  = 0;
	int mismatches        = 0;
	int quiet_cycles      = 0;

	one_bit_rc_audio_encoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.sample_last (sample_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.packed_byte (packed_byte),
		.bits_valid  (bits_valid),
		.stream_end  (stream_end)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Encode one accepted sample and queue the byte it completes, if any.
	task automatic encode_sample(input logic [7:0] value, input logic last);
		logic [LEVEL_W-1:0] divisor;
		logic [LEVEL_W-1:0] target;
		logic [LEVEL_W-1:0] level_hi;
		logic [LEVEL_W-1:0] level_lo;
		logic [LEVEL_W-1:0] dist_hi;
		logic [LEVEL_W-1:0] dist_lo;
		logic [2:0]         slot;
		logic               enc;
		divisor  = (cfg_softness == '0) ? 9'd1 : {1'b0, cfg_softness};
		target   = {1'b0, value >> 1} + TARGET_BIAS;
		level_hi = level + (LEVEL_FULL - level) / divisor;
		level_lo = level - level / divisor;
		dist_hi  = (level_hi > target) ? level_hi - target : target - level_hi;
		dist_lo  = (level_lo > target) ? level_lo - target : target - level_lo;
		// a tie charges towards the high level
		enc      = (dist_hi <= dist_lo);
		level    = enc ? level_hi : level_lo;
		slot     = cfg_msb_first ? 3'd7 - bits_packed[2:0] : bits_packed[2:0];
		if (enc) begin
			byte_acc[slot] = 1'b1;
		end
		bits_packed = bits_packed + 4'd1;
		if (bits_packed == 4'd8 || last) begin
			expected_bytes.push_back('{byte_acc, bits_packed, last});
			byte_acc    = '0;
			bits_packed = '0;
			if (last) begin
				level = LEVEL_RESET;
			end
		end
	endtask

	task automatic queue_sample(input logic [7:0] value, input logic last);
		sample_queue.push_back('{value, last});
		items_queued++;
	endtask

	task automatic queue_directed(input int first, input int count);
		for (int i = first; i < first + count; i++) begin
			queue_sample(DIRECTED_SAMPLES[i], DIRECTED_LAST[i]);
		end
	endtask

	task automatic queue_stream(input int length, input wave_t style, input logic close);
		int value;
		value = $urandom_range(255);
		for (int i = 0; i < length; i++) begin
			case (style)
				WAVE_UNIFORM: value = $urandom_range(255);
				WAVE_WALK: begin
					value += int'($urandom_range(48)) - 24;
					if (value < 0) value = 0;
					if (value > 255) value = 255;
				end
				WAVE_RAILS: value = $urandom_range(1) ? 255 : 0;
				default: ;
			endcase
			queue_sample(value[7:0], close && (i == length - 1));
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == CFG_SOFTNESS) begin
			cfg_softness = data;
		end else begin
			cfg_msb_first = data[0];
		end
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_SENDER: begin
				sender_idle_pct    = 49;
				receiver_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				sender_idle_pct    = 0;
				receiver_stall_pct = 49;
			end
			IDLE_BOTH: begin
				sender_idle_pct    = 10;
				receiver_stall_pct = 10;
			end
			default: begin
				sender_idle_pct    = 0;
				receiver_stall_pct = 0;
			end
		endcase
	endtask

	// Hold off until every queued sample is taken and every byte has come,
	// then let a sample that completes no byte finish.
	task automatic settle();
		while (sample_queue.size() != 0 || in_valid || expected_bytes.size() != 0) begin
			@(negedge clk);
		end
		repeat (LATENCY_CYCLES) @(posedge clk);
	endtask

	// Sample driver
	always @(posedge clk) begin : drive_samples
		logic         send_next;
		sample_item_t next_item;
		if (arst_n && (!in_valid || in_ready)) begin
			send_next = (sample_queue.size() != 0) &&
				($urandom_range(99) >= sender_idle_pct);
			if (send_next) begin
				next_item = sample_queue.pop_front();
				sample      <= next_item.value;
				sample_last <= next_item.last;
			end
			in_valid <= send_next;
		end
	end

	always @(posedge clk) begin
		out_ready <= arst_n && ($urandom_range(99) >= receiver_stall_pct);
	end

	// Predict on accepted samples, check accepted bytes
	always @(posedge clk) begin : watch_results
		packed_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				encode_sample(sample, sample_last);
				samples_taken++;
			end
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					$error("byte with no sample behind it: packed_byte %0h bits_valid %0d",
						packed_byte, bits_valid);
					mismatches++;
				end else begin
					want = expected_bytes.pop_front();
					bytes_checked++;
					if (want.end_flag) streams_closed++;
					if (packed_byte !== want.code) begin
						$error("packed_byte: expected %0h, got %0h", want.code, packed_byte);
						mismatches++;
					end
					if (bits_valid !== want.count) begin
						$error("bits_valid: expected %0d, got %0d", want.count, bits_valid);
						mismatches++;
					end
					if (stream_end !== want.end_flag) begin
						$error("stream_end: expected %0b, got %0b", want.end_flag, stream_end);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$error("no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [7:0] soft_val;
		logic [7:0] msb_word;
		int         phase_end;
		int         length;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: full byte ending a stream, short streams, open tail
		set_idling(IDLE_NONE);
		settings_applied++;
		queue_directed(0, 14);
		settle();

		// Flip the order mid-byte, charge the full distance
		write_reg(CFG_SOFTNESS, 8'd1);
		write_reg(CFG_MSB_FIRST, 8'd1);
		settings_applied++;
		queue_directed(14, 5);
		settle();

		write_reg(CFG_SOFTNESS, 8'd0);
		write_reg(CFG_MSB_FIRST, 8'd0);
		settings_applied++;
		queue_directed(19, 3);
		settle();

		write_reg(CFG_SOFTNESS, 8'd255);
		write_reg(CFG_MSB_FIRST, 8'hFF);
		settings_applied++;
		queue_directed(22, 3);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: soft_val = 8'd1;
				1: soft_val = 8'd255;
				2: soft_val = 8'd2;
				3: soft_val = 8'($urandom_range(1, 16));
				4: soft_val = 8'd0;
				5: soft_val = 8'($urandom_range(255));
				6: soft_val = 8'd4;
				default: soft_val = 8'($urandom_range(1, 255));
			endcase
			msb_word = 8'($urandom_range(255));
			if ($urandom_range(1)) begin
				write_reg(CFG_SOFTNESS, soft_val);
				write_reg(CFG_MSB_FIRST, msb_word);
			end else begin
				write_reg(CFG_MSB_FIRST, msb_word);
				write_reg(CFG_SOFTNESS, soft_val);
			end
			settings_applied++;
			set_idling(idle_mode_t'(p % 4));
			phase_end = items_queued + ITEMS_PER_PHASE;
			while (items_queued < phase_end) begin
				length = ($urandom_range(4) == 0) ? 8 * $urandom_range(1, 3)
					: $urandom_range(1, 24);
				// leave the odd stream open so it runs on into the next one
				queue_stream(length, wave_t'($urandom_range(3)), $urandom_range(9) != 0);
			end
			settle();
		end

		$display("Covered %0d samples and %0d packed bytes (%0d stream ends) under %0d settings",
			samples_taken, bytes_checked, streams_closed, settings_applied);
		$display("Idling cycled through none, sender only, receiver only and both sides");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/orbe_pkg.sv
rtl/orbe_div.sv
rtl/orbe_pack.sv
rtl/one_bit_rc_audio_encoder.sv
verif/tb_top.sv
